// ===== rtl/core/rmdc_pkg.sv =====
// ============================================================================
// rmdc_pkg
// Shared types and constants for the reversing door motor controller.
// ============================================================================
`default_nettype none

package rmdc_pkg;

  // Default width of the elapsed tick counter
  localparam int unsigned TIMER_BITS_DEF = 20;

  // Configuration register widths and reset values
  localparam int unsigned DEAD_W         = 16;
  localparam int unsigned TIMEOUT_W      = 20;
  localparam int unsigned CFG_DATA_W     = 20;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam logic [DEAD_W-1:0]    DEAD_TIME_RST = 16'd200;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd30000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIMEOUT = 1'd1;

  // Input word kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  // Command codes (any other code acts as open)
  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_REV   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DRV_BRAKE = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } drive_t;

  // Live configuration handed to the state machine
  typedef struct packed {
    logic [DEAD_W-1:0]    dead_time;
    logic [TIMEOUT_W-1:0] run_timeout;
  } cfg_t;

  // One result word
  typedef struct packed {
    mode_t  mode;
    drive_t drive;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmdc_in_if.sv =====
// ============================================================================
// rmdc_in_if
// Input channel: tick or command words with valid/ready handshake.
// ============================================================================
`default_nettype none

interface rmdc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] command_code;

  modport source (output valid, output func, output command_code, input ready);
  modport sink   (input valid, input func, input command_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rmdc_out_if.sv =====
// ============================================================================
// rmdc_out_if
// Result channel: door mode and bridge drive with valid/ready handshake.
// ============================================================================
`default_nettype none

interface rmdc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] door_mode;
  logic [1:0] drive;

  modport source (output valid, output door_mode, output drive, input ready);
  modport sink   (input valid, input door_mode, input drive, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rmdc_cfg_regs.sv =====
// ============================================================================
// rmdc_cfg_regs
// Dead time and run timeout registers behind a plain write port.
// ============================================================================
`default_nettype none

module rmdc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rmdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rmdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rmdc_pkg::cfg_t                        cfg
);

  logic [rmdc_pkg::DEAD_W-1:0]    dead_time_r;
  logic [rmdc_pkg::TIMEOUT_W-1:0] run_timeout_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_time_r   <= rmdc_pkg::DEAD_TIME_RST;
      run_timeout_r <= rmdc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rmdc_pkg::REG_DEAD_TIME:   dead_time_r   <= cfg_wdata[rmdc_pkg::DEAD_W-1:0];
        rmdc_pkg::REG_RUN_TIMEOUT: run_timeout_r <= cfg_wdata[rmdc_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dead_time   = dead_time_r;
  assign cfg.run_timeout = run_timeout_r;

endmodule

`default_nettype wire

// ===== rtl/core/rmdc_fsm.sv =====
// ============================================================================
// rmdc_fsm
// Door mode state machine with reversing dead time and run timeout.
// ============================================================================
`default_nettype none

module rmdc_fsm #(
  parameter int unsigned TIMER_BITS = rmdc_pkg::TIMER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        func,
  input  wire logic [1:0]  command_code,
  input  wire rmdc_pkg::cfg_t cfg,
  output rmdc_pkg::result_t result_nxt
);

  // Compare width covers the counter and the widest limit
  localparam int unsigned CMP_W =
    (TIMER_BITS > rmdc_pkg::TIMEOUT_W) ? TIMER_BITS : rmdc_pkg::TIMEOUT_W;

  rmdc_pkg::mode_t        mode_r, mode_nxt;
  rmdc_pkg::drive_t       drive_r, drive_nxt;
  logic                   target_close_r, target_close_nxt;
  logic [TIMER_BITS-1:0]  elapsed_r, elapsed_nxt;

  logic [TIMER_BITS-1:0]  elapsed_inc;
  logic                   close_req;
  rmdc_pkg::mode_t        want_mode;
  logic                   dead_done;
  logic                   run_done;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= rmdc_pkg::MODE_STOP;
      drive_r        <= rmdc_pkg::DRV_BRAKE;
      target_close_r <= 1'b0;
      elapsed_r      <= '0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      drive_r        <= drive_nxt;
      target_close_r <= target_close_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

  // Saturating tick count and limit checks
  assign elapsed_inc = (elapsed_r == {TIMER_BITS{1'b1}}) ? elapsed_r
                                                         : elapsed_r + 1'b1;
  assign dead_done   = CMP_W'(elapsed_inc) >= CMP_W'(cfg.dead_time);
  assign run_done    = CMP_W'(elapsed_inc) >= CMP_W'(cfg.run_timeout);
  assign close_req   = (command_code == rmdc_pkg::CMD_CLOSE);
  assign want_mode   = close_req ? rmdc_pkg::MODE_CLOSE : rmdc_pkg::MODE_OPEN;

  // Next state for one word
  always_comb begin
    mode_nxt         = mode_r;
    drive_nxt        = drive_r;
    target_close_nxt = target_close_r;
    elapsed_nxt      = elapsed_r;
    if (func == rmdc_pkg::FUNC_CMD) begin
      if (command_code == rmdc_pkg::CMD_STOP) begin
        mode_nxt  = rmdc_pkg::MODE_STOP;
        drive_nxt = rmdc_pkg::DRV_BRAKE;
      end else if (mode_r != want_mode) begin
        case (mode_r)
          rmdc_pkg::MODE_STOP: begin
            mode_nxt    = want_mode;
            drive_nxt   = close_req ? rmdc_pkg::DRV_CLOSE : rmdc_pkg::DRV_OPEN;
            elapsed_nxt = '0;
          end
          rmdc_pkg::MODE_REV: begin
            // new target restarts the dead time
            if (close_req != target_close_r) begin
              target_close_nxt = close_req;
              elapsed_nxt      = '0;
            end
          end
          default: begin
            // moving the other way: brake first
            mode_nxt         = rmdc_pkg::MODE_REV;
            drive_nxt        = rmdc_pkg::DRV_BRAKE;
            target_close_nxt = close_req;
            elapsed_nxt      = '0;
          end
        endcase
      end
    end else begin
      elapsed_nxt = elapsed_inc;
      case (mode_r)
        rmdc_pkg::MODE_REV: begin
          if (dead_done) begin
            mode_nxt    = target_close_r ? rmdc_pkg::MODE_CLOSE : rmdc_pkg::MODE_OPEN;
            drive_nxt   = target_close_r ? rmdc_pkg::DRV_CLOSE : rmdc_pkg::DRV_OPEN;
            elapsed_nxt = '0;
          end
        end
        rmdc_pkg::MODE_OPEN, rmdc_pkg::MODE_CLOSE: begin
          if (run_done) begin
            mode_nxt  = rmdc_pkg::MODE_STOP;
            drive_nxt = rmdc_pkg::DRV_BRAKE;
          end
        end
        default: ;
      endcase
    end
  end

  assign result_nxt.mode  = mode_nxt;
  assign result_nxt.drive = drive_nxt;

endmodule

`default_nettype wire

// ===== rtl/core/rmdc_out_stage.sv =====
// ============================================================================
// rmdc_out_stage
// Result register; frees the input side whenever it is empty or drained.
// ============================================================================
`default_nettype none

module rmdc_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire rmdc_pkg::result_t result_nxt,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic               can_load,
  output rmdc_pkg::result_t  result
);

  logic              valid_r;
  rmdc_pkg::result_t result_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = valid_r;
  assign can_load  = !valid_r || out_ready;
  assign result    = result_r;

endmodule

`default_nettype wire

// ===== rtl/core/reversing_motor_door_controller_top.sv =====
// ============================================================================
// reversing_motor_door_controller_top
// Door motor H-bridge controller with reversing dead time and run timeout.
// ============================================================================
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+-------------------------------
//  in_ch    | in  | valid/ready       | func, command_code
//  out_ch   | out | valid/ready       | door_mode, drive
//  cfg_*    | in  | cfg_we, no ready  | cfg_index, cfg_wdata (20 bits)
//
//  One word per cycle unless out_ch stalls; its result appears in the output
//  register in the cycle after acceptance. State update and result load happen
//  in the accepting cycle, so throughput is set only by the output register.
//  in_ch.ready is high when the output register is empty or being drained.
//  Synchronous active-low reset; no clearing pass is needed.
// ============================================================================
`default_nettype none

module reversing_motor_door_controller_top #(
  parameter int unsigned TIMER_BITS = rmdc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rmdc_in_if.sink                               in_ch,
  rmdc_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [rmdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rmdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rmdc_pkg::cfg_t    cfg;
  rmdc_pkg::result_t result_nxt;
  rmdc_pkg::result_t result;
  logic              can_load;
  logic              accept;

  assign accept      = in_ch.valid && can_load;
  assign in_ch.ready = can_load;

  rmdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rmdc_fsm #(
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .func         (in_ch.func),
    .command_code (in_ch.command_code),
    .cfg          (cfg),
    .result_nxt   (result_nxt)
  );

  rmdc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result_nxt (result_nxt),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .can_load   (can_load),
    .result     (result)
  );

  assign out_ch.door_mode = result.mode;
  assign out_ch.drive     = result.drive;

endmodule

`default_nettype wire

// ===== rtl/core/rmdc_checker.sv =====
// ============================================================================
// rmdc_checker
// Port-level checks for the door motor controller, bound to the top level.
// ============================================================================
`default_nettype none

module rmdc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_func,
  input wire logic [1:0] in_command_code,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_door_mode,
  input wire logic [1:0] out_drive
);

  // Result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_door_mode) && $stable(out_drive))
    else $error("result word changed while stalled");

  // Input side never stalls on an empty output register
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Stop command brakes at once
  a_stop_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == rmdc_pkg::FUNC_CMD) &&
    (in_command_code == rmdc_pkg::CMD_STOP)
    |=> out_valid && (out_door_mode == rmdc_pkg::MODE_STOP) &&
        (out_drive == rmdc_pkg::DRV_BRAKE))
    else $error("stop command did not brake");

  // Drive agrees with mode
  a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_door_mode == rmdc_pkg::MODE_OPEN)  && (out_drive == rmdc_pkg::DRV_OPEN))  ||
      ((out_door_mode == rmdc_pkg::MODE_CLOSE) && (out_drive == rmdc_pkg::DRV_CLOSE)) ||
      ((out_door_mode == rmdc_pkg::MODE_STOP)  && (out_drive == rmdc_pkg::DRV_BRAKE)) ||
      ((out_door_mode == rmdc_pkg::MODE_REV)   && (out_drive == rmdc_pkg::DRV_BRAKE)))
    else $error("drive does not match door mode");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind reversing_motor_door_controller_top rmdc_checker u_rmdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .in_command_code (in_ch.command_code),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_door_mode   (out_ch.door_mode),
  .out_drive       (out_ch.drive)
);

`default_nettype wire
